// ===== hw/rtl/cndf_pkg.sv =====
// Shared types, constants and helper functions of the cross-neighbour despeckle filter.
// Used by the line memory, the filter kernel, the top level and the port checker.
// Depends on nothing.
package cndf_pkg;

  // Default sizes of the frame store.
  localparam int MAX_COLS_DEF = 32;
  localparam int MAX_ROWS_DEF = 64;

  // Fixed field widths.
  localparam int LEVEL_BITS  = 4;
  localparam int GLYPH_W     = 7;
  localparam int OUT_ROW_W   = 6;
  localparam int OUT_COL_W   = 5;
  localparam int FW_W        = 6;
  localparam int FH_W        = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_COL_W - OUT_ROW_W - GLYPH_W - LEVEL_BITS;

  // Highest grey level.
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 4'd9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 6'd30;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 7'd20;

  // Line store banks: three rows rotate through them.
  localparam int BANK_W = 2;
  localparam logic [BANK_W-1:0] BANK_LAST = 2'd2;

  // Neighbour slots of the kernel.
  localparam int NB_LEFT  = 0;
  localparam int NB_RIGHT = 1;
  localparam int NB_UP    = 2;
  localparam int NB_DOWN  = 3;
  localparam int NB_NUM   = 4;

  typedef logic [LEVEL_BITS-1:0] level_t;

  // Gathered neighbourhood of one pixel, with an in-frame flag per neighbour.
  typedef struct packed {
    level_t                  centre;
    level_t [NB_NUM-1:0]     nb;
    logic   [NB_NUM-1:0]     nb_ok;
  } nbhd_t;

  // Filtered pixel.
  typedef struct packed {
    level_t               level;
    logic [GLYPH_W-1:0]   glyph;
    logic                 replaced;
  } kres_t;

  // Levels 0..9 map to space . ' : ~ * = $ % #
  function automatic logic [GLYPH_W-1:0] glyph_of(level_t lv);
    logic [GLYPH_W-1:0] g;
    case (lv)
      4'd0:    g = 7'd32;
      4'd1:    g = 7'd46;
      4'd2:    g = 7'd39;
      4'd3:    g = 7'd58;
      4'd4:    g = 7'd126;
      4'd5:    g = 7'd42;
      4'd6:    g = 7'd61;
      4'd7:    g = 7'd36;
      4'd8:    g = 7'd37;
      default: g = 7'd35;
    endcase
    return g;
  endfunction

  // Inputs above the top level clip to it.
  function automatic level_t sat_level(logic [LEVEL_BITS-1:0] raw);
    return (raw > LEVEL_MAX) ? LEVEL_MAX : raw;
  endfunction

  // Average rounded half up, floor((2*sum + cnt) / (2*cnt)) for cnt 1..4.
  // The divide by six for three neighbours is a multiply by 43/256, exact
  // for the numerators below 64 that can occur.
  function automatic level_t avg_round(logic [5:0] sum, logic [2:0] cnt);
    logic [6:0]  num3;
    logic [12:0] prod;
    logic [5:0]  res;
    num3 = {sum, 1'b0} + 7'd3;
    prod = 13'(num3) * 13'd43;
    case (cnt)
      3'd2:    res = 6'((7'(sum) + 7'd1) >> 1);
      3'd3:    res = {1'b0, prod[12:8]};
      3'd4:    res = 6'((7'(sum) + 7'd2) >> 2);
      default: res = sum;
    endcase
    return (res > 6'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_BITS'(res);
  endfunction

endpackage

// ===== hw/rtl/cndf_line_mem.sv =====
// Line store of the despeckle filter: one write port, one read port, registered read data.
// Holds three rows of grey levels in rotating banks.
// Depends on cndf_pkg.
module cndf_line_mem #(
  parameter int DEPTH  = 3 * cndf_pkg::MAX_COLS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ADDR_W-1:0]      waddr_i,
  input  cndf_pkg::level_t       wdata_i,
  input  logic                   re_i,
  input  logic [ADDR_W-1:0]      raddr_i,
  output cndf_pkg::level_t       rdata_o
);

  cndf_pkg::level_t mem_q [DEPTH];
  cndf_pkg::level_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cndf_kernel.sv =====
// Filter kernel of the despeckle filter: neighbour count, outlier test and rounded average.
// Purely combinational; the caller registers the result.
// Depends on cndf_pkg.
module cndf_kernel (
  input  cndf_pkg::nbhd_t nbhd_i,
  output cndf_pkg::kres_t res_o
);

  always_comb begin
    logic [5:0]         sum;
    logic [2:0]         cnt;
    logic               flag;
    cndf_pkg::level_t   diff;
    cndf_pkg::level_t   lv;
    sum  = '0;
    cnt  = '0;
    flag = 1'b0;
    // Only nonzero neighbours inside the frame take part.
    for (int i = 0; i < cndf_pkg::NB_NUM; i++) begin
      diff = (nbhd_i.nb[i] > nbhd_i.centre) ? nbhd_i.nb[i] - nbhd_i.centre
                                           : nbhd_i.centre - nbhd_i.nb[i];
      if (nbhd_i.nb_ok[i] && (nbhd_i.nb[i] != '0)) begin
        sum = sum + 6'(nbhd_i.nb[i]);
        cnt = cnt + 3'd1;
        if (diff > 4'd1) begin
          flag = 1'b1;
        end
      end
    end
    flag = flag && (cnt != 3'd0);
    lv   = flag ? cndf_pkg::avg_round(sum, cnt) : nbhd_i.centre;
    if (lv > cndf_pkg::LEVEL_MAX) begin
      lv = cndf_pkg::LEVEL_MAX;
    end
    res_o.level    = lv;
    res_o.glyph    = cndf_pkg::glyph_of(lv);
    res_o.replaced = flag;
  end

endmodule

// ===== hw/rtl/cross_neighbour_despeckle_filter.sv =====
// Top level of the cross-neighbour despeckle filter: stream ports, sequencer, output register.
// Instantiates cndf_line_mem and cndf_kernel; depends on cndf_pkg.
//
// The block takes a raster of grey levels one pixel per transfer, clips levels above 9 to 9,
// and for every pixel looks at its in-frame up, down, left and right neighbours, counting only
// nonzero ones. When a counted neighbour differs from the pixel by more than one level, the
// pixel is replaced by the counted neighbours' average rounded half up; otherwise it passes.
// Each result carries the level, its ASCII glyph, a replaced flag and its row and column.
// Results lag the input by one row: the pixel at row r >= 1 releases the pixel above it, and
// the last pixel of the frame also releases the whole last row, with tlast marking the final
// result of each input transfer. Rows live in one line memory of three banks that rotate at
// each row end but the frame's last; the memory has a single read port, so each result is
// gathered by four neighbourhood reads (up, left, centre, right) and then the filter step. A
// pixel of the first row other than the frame's last is taken without leaving the idle state;
// any other pixel holds the input until its results are out, longer while the output stalls.
// A finished result waits in the output register while the next pixel is taken. The line
// memory needs no clearing after reset. A configuration write restarts the frame and keeps
// the stored rows; writes are meant to happen only while the block is idle.
module cross_neighbour_despeckle_filter #(
  parameter int MAX_COLS = cndf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = cndf_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [cndf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [3:0] pixel_level
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [3:0] level_out, [10:4] glyph_code, [16:11] out_row, [21:17] out_col
  output logic [cndf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tuser,   // [0] was_replaced
  output logic                                 m_axis_tlast,   // last_of_run
  // Configuration writes
  input  logic                                 cfg_we_i,
  input  logic [cndf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cndf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WW     = $clog2(MAX_COLS + 1);
  localparam int WC_W   = (WW > cndf_pkg::FW_W + 1) ? WW : cndf_pkg::FW_W + 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HW     = $clog2(MAX_ROWS + 1);
  localparam int HC_W   = (HW > cndf_pkg::FH_W) ? HW : cndf_pkg::FH_W;
  localparam int DEPTH  = 3 * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Sequencer states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Read steps of one result.
  localparam logic [2:0] STEP_UP    = 3'd0;
  localparam logic [2:0] STEP_LEFT  = 3'd1;
  localparam logic [2:0] STEP_MID   = 3'd2;
  localparam logic [2:0] STEP_RIGHT = 3'd3;
  localparam logic [2:0] STEP_CALC  = 3'd4;

  // Emit phases: the pixel one row up, then the flush of the last row.
  localparam logic PH_ABOVE = 1'b0;
  localparam logic PH_FLUSH = 1'b1;

  function automatic logic [cndf_pkg::BANK_W-1:0] bank_dec(logic [cndf_pkg::BANK_W-1:0] b);
    return (b == '0) ? cndf_pkg::BANK_LAST : b - 2'd1;
  endfunction

  function automatic logic [cndf_pkg::BANK_W-1:0] bank_inc(logic [cndf_pkg::BANK_W-1:0] b);
    return (b == cndf_pkg::BANK_LAST) ? '0 : b + 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(logic [cndf_pkg::BANK_W-1:0] b,
                                                 logic [COL_W-1:0] col);
    return ADDR_W'(b) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  // Configuration and frame position.
  logic [cndf_pkg::FW_W-1:0]     fw_q;
  logic [cndf_pkg::FH_W-1:0]     fh_q;
  logic [COL_W-1:0]              col_q, col_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [cndf_pkg::BANK_W-1:0]   bank_q, bank_d;

  // Job of the current input transfer.
  logic                          state_q, state_d;
  logic [2:0]                    step_q, step_d;
  logic                          phase_q, phase_d;
  logic                          flush_pend_q, flush_pend_d;
  logic [COL_W-1:0]              ecol_q, ecol_d;
  logic [ROW_W-1:0]              jrow_q, jrow_d;
  logic [cndf_pkg::BANK_W-1:0]   jbank_q, jbank_d;
  cndf_pkg::level_t              pix_q, pix_d;

  // Gathered neighbourhood.
  cndf_pkg::level_t              up_q, left_q, centre_q;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  cndf_pkg::level_t              out_level_q, out_level_d;
  logic [cndf_pkg::GLYPH_W-1:0]  out_glyph_q, out_glyph_d;
  logic                          out_repl_q, out_repl_d;
  logic [cndf_pkg::OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [cndf_pkg::OUT_COL_W-1:0] out_col_q, out_col_d;
  logic                          out_last_q, out_last_d;

  logic [WW-1:0]                 eff_w;
  logic [HC_W-1:0]               eff_h;
  logic                          in_fire, col_last, row_last, frame_end;
  logic                          up_ok, down_ok, left_ok, right_ok;
  logic [cndf_pkg::BANK_W-1:0]   up_bank, mid_bank;
  logic [ROW_W-1:0]              erow;
  logic [COL_W-1:0]              lcol, rcol;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_raddr;
  cndf_pkg::level_t              mem_rdata;
  cndf_pkg::level_t              pix_in;
  cndf_pkg::nbhd_t               nbhd;
  cndf_pkg::kres_t               kres;
  logic                          out_free, load;

  // Effective frame size: zero acts as one, oversize clips to the store.
  always_comb begin
    if (fw_q == '0) begin
      eff_w = WW'(1);
    end else if (WC_W'(fw_q) > WC_W'(MAX_COLS)) begin
      eff_w = WW'(MAX_COLS);
    end else begin
      eff_w = WW'(fw_q);
    end
    if (fh_q == '0) begin
      eff_h = HC_W'(1);
    end else if (HC_W'(fh_q) > HC_W'(MAX_ROWS)) begin
      eff_h = HC_W'(MAX_ROWS);
    end else begin
      eff_h = HC_W'(fh_q);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign pix_in        = cndf_pkg::sat_level(s_axis_tdata[cndf_pkg::LEVEL_BITS-1:0]);
  assign col_last      = (WW'(col_q) + WW'(1)) == eff_w;
  assign row_last      = (HC_W'(row_q) + HC_W'(1)) == eff_h;
  assign frame_end     = col_last && row_last;

  // Neighbourhood of the pixel being emitted. Above-row emits use the row two back as up,
  // the row one back as centre row and the fresh input as down; the flush uses the row one
  // back as up and the current row as centre row, with nothing below.
  always_comb begin
    if (phase_q == PH_ABOVE) begin
      up_ok    = (jrow_q > ROW_W'(1));
      up_bank  = bank_dec(bank_dec(jbank_q));
      mid_bank = bank_dec(jbank_q);
      down_ok  = 1'b1;
      erow     = jrow_q - ROW_W'(1);
    end else begin
      up_ok    = (jrow_q != '0);
      up_bank  = bank_dec(jbank_q);
      mid_bank = jbank_q;
      down_ok  = 1'b0;
      erow     = jrow_q;
    end
  end

  assign left_ok  = (ecol_q != '0);
  assign right_ok = (WW'(ecol_q) + WW'(1)) < eff_w;
  // Out-of-frame neighbours read the centre column so the address stays inside the bank.
  assign lcol     = left_ok ? ecol_q - COL_W'(1) : ecol_q;
  assign rcol     = right_ok ? ecol_q + COL_W'(1) : ecol_q;

  assign mem_re = (state_q == ST_READ) && (step_q < STEP_CALC);

  always_comb begin
    case (step_q)
      STEP_UP:    mem_raddr = mem_addr(up_bank, ecol_q);
      STEP_LEFT:  mem_raddr = mem_addr(mid_bank, lcol);
      STEP_MID:   mem_raddr = mem_addr(mid_bank, ecol_q);
      STEP_RIGHT: mem_raddr = mem_addr(mid_bank, rcol);
      default:    mem_raddr = mem_addr(mid_bank, ecol_q);
    endcase
  end

  // Writes happen only on an input transfer while no reads are outstanding, so the store
  // needs no forwarding.
  cndf_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (mem_addr(bank_q, col_q)),
    .wdata_i (pix_in),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    nbhd.centre                  = centre_q;
    nbhd.nb[cndf_pkg::NB_LEFT]   = left_q;
    nbhd.nb[cndf_pkg::NB_RIGHT]  = mem_rdata;
    nbhd.nb[cndf_pkg::NB_UP]     = up_q;
    nbhd.nb[cndf_pkg::NB_DOWN]   = pix_q;
    nbhd.nb_ok[cndf_pkg::NB_LEFT]  = left_ok;
    nbhd.nb_ok[cndf_pkg::NB_RIGHT] = right_ok;
    nbhd.nb_ok[cndf_pkg::NB_UP]    = up_ok;
    nbhd.nb_ok[cndf_pkg::NB_DOWN]  = down_ok;
  end

  cndf_kernel u_kernel (
    .nbhd_i (nbhd),
    .res_o  (kres)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign load     = (state_q == ST_READ) && (step_q == STEP_CALC) && out_free;

  // Sequencer and frame position.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    phase_d      = phase_q;
    flush_pend_d = flush_pend_q;
    ecol_d       = ecol_q;
    jrow_d       = jrow_q;
    jbank_d      = jbank_q;
    pix_d        = pix_q;
    col_d        = col_q;
    row_d        = row_q;
    bank_d       = bank_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pix_d        = pix_in;
          jrow_d       = row_q;
          jbank_d      = bank_q;
          step_d       = STEP_UP;
          flush_pend_d = frame_end;
          if (row_q != '0) begin
            state_d = ST_READ;
            phase_d = PH_ABOVE;
            ecol_d  = col_q;
          end else if (frame_end) begin
            // A one-row frame only emits its flush.
            state_d = ST_READ;
            phase_d = PH_FLUSH;
            ecol_d  = '0;
          end
          if (frame_end) begin
            col_d = '0;
            row_d = '0;
          end else if (col_last) begin
            col_d  = '0;
            row_d  = row_q + ROW_W'(1);
            bank_d = bank_inc(bank_q);
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      end
      ST_READ: begin
        if (step_q != STEP_CALC) begin
          step_d = step_q + 3'd1;
        end else if (load) begin
          step_d = STEP_UP;
          if ((phase_q == PH_ABOVE) && flush_pend_q) begin
            phase_d = PH_FLUSH;
            ecol_d  = '0;
          end else if ((phase_q == PH_FLUSH) && right_ok) begin
            ecol_d = ecol_q + COL_W'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write restarts the frame; stored rows stay.
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // Output register: loaded from the kernel, drained by the output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_level_d = out_level_q;
    out_glyph_d = out_glyph_q;
    out_repl_d  = out_repl_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_level_d = kres.level;
      out_glyph_d = kres.glyph;
      out_repl_d  = kres.replaced;
      out_row_d   = cndf_pkg::OUT_ROW_W'(erow);
      out_col_d   = cndf_pkg::OUT_COL_W'(ecol_q);
      out_last_d  = (phase_q == PH_ABOVE) ? !flush_pend_q : !right_ok;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q         <= cndf_pkg::FRAME_WIDTH_RST;
      fh_q         <= cndf_pkg::FRAME_HEIGHT_RST;
      col_q        <= '0;
      row_q        <= '0;
      bank_q       <= '0;
      state_q      <= ST_IDLE;
      step_q       <= STEP_UP;
      phase_q      <= PH_ABOVE;
      flush_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == cndf_pkg::REG_FRAME_WIDTH)) begin
        fw_q <= cfg_wdata_i[cndf_pkg::FW_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == cndf_pkg::REG_FRAME_HEIGHT)) begin
        fh_q <= cfg_wdata_i[cndf_pkg::FH_W-1:0];
      end
      col_q        <= col_d;
      row_q        <= row_d;
      bank_q       <= bank_d;
      state_q      <= state_d;
      step_q       <= step_d;
      phase_q      <= phase_d;
      flush_pend_q <= flush_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ecol_q      <= ecol_d;
    jrow_q      <= jrow_d;
    jbank_q     <= jbank_d;
    pix_q       <= pix_d;
    out_level_q <= out_level_d;
    out_glyph_q <= out_glyph_d;
    out_repl_q  <= out_repl_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_last_q  <= out_last_d;
    if (state_q == ST_READ) begin
      if (step_q == STEP_LEFT) begin
        up_q <= mem_rdata;
      end
      if (step_q == STEP_MID) begin
        left_q <= mem_rdata;
      end
      if (step_q == STEP_RIGHT) begin
        centre_q <= mem_rdata;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{cndf_pkg::OUT_PAD_W{1'b0}}, out_col_q, out_row_q,
                          out_glyph_q, out_level_q};
  assign m_axis_tuser  = out_repl_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hw/rtl/cndf_checker.sv =====
// Port-level checker of the cross-neighbour despeckle filter, bound to the top level.
// Depends on cndf_pkg and on cross_neighbour_despeckle_filter.
module cndf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [cndf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast
);

  // A stalled result holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Levels stay within 0..9.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= cndf_pkg::LEVEL_MAX)
    else $error("level out of range");

  // The glyph always belongs to the level it travels with.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:4] == cndf_pkg::glyph_of(m_axis_tdata[3:0]))
    else $error("glyph does not match level");

  // A result is only produced while the sequencer is busy with an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind cross_neighbour_despeckle_filter cndf_checker u_cndf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
